>>> sv/psu_pkg.sv
// Package for the particle swarm update block: item types, codes, fixed constants.
// No dependencies.
`default_nettype none
package psu_pkg;
	localparam logic [1:0] FUNC_MOVE   = 2'd0;
	localparam logic [1:0] FUNC_REPORT = 2'd1;
	localparam logic [1:0] FUNC_LOAD   = 2'd2;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	localparam logic [2:0] REG_INERTIA = 3'd0;
	localparam logic [2:0] REG_GPULL   = 3'd1;
	localparam logic [2:0] REG_LPULL   = 3'd2;
	localparam logic [2:0] REG_VSCALE  = 3'd3;
	localparam logic [2:0] REG_WRAP    = 3'd4;
	localparam logic [2:0] REG_NPART   = 3'd5;
	localparam logic [2:0] REG_NDIM    = 3'd6;

	localparam logic signed [31:0] TWO_PI_Q16 = 32'sd411775;

	typedef struct packed {
		logic [1:0]         func;
		logic [5:0]         particle_id;
		logic [3:0]         dim_index;
		logic signed [31:0] value;
		logic signed [31:0] upper;
		logic signed [31:0] fitness;
		logic [15:0]        r_global;
		logic [15:0]        r_local;
		logic [15:0]        rand_pos;
		logic [15:0]        rand_other;
		logic               last;
	} psu_in_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [5:0]         particle_out;
		logic [3:0]         dim_out;
		logic signed [31:0] position;
		logic signed [31:0] velocity;
		logic               local_improved;
		logic               global_improved;
		logic               last_out;
	} psu_out_t;

	typedef struct packed {
		logic [15:0] inertia_weight;
		logic [15:0] global_pull_weight;
		logic [15:0] local_pull_weight;
		logic [15:0] init_velocity_scale;
		logic        radian_wrap_enable;
		logic [6:0]  particles_in_use;
		logic [4:0]  dims_in_use;
	} psu_cfg_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647) return 32'sh7fffffff;
		if (x < -64'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction
endpackage
`default_nettype wire

>>> sv/psu_regs.sv
// Configuration register file on an APB-style port.
// Depends on psu_pkg.
`default_nettype none
module psu_regs import psu_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output psu_cfg_t         cfg
);
	psu_cfg_t cfg_q;
	logic [2:0] idx;
	assign idx = paddr[4:2];
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inertia_weight      <= 16'd3072;
			cfg_q.global_pull_weight  <= 16'd6144;
			cfg_q.local_pull_weight   <= 16'd6144;
			cfg_q.init_velocity_scale <= 16'd1024;
			cfg_q.radian_wrap_enable  <= 1'b0;
			cfg_q.particles_in_use    <= 7'd64;
			cfg_q.dims_in_use         <= 5'd16;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
			unique case (idx)
				REG_INERTIA: cfg_q.inertia_weight      <= pwdata[15:0];
				REG_GPULL:   cfg_q.global_pull_weight  <= pwdata[15:0];
				REG_LPULL:   cfg_q.local_pull_weight   <= pwdata[15:0];
				REG_VSCALE:  cfg_q.init_velocity_scale <= pwdata[15:0];
				REG_WRAP:    cfg_q.radian_wrap_enable  <= pwdata[0];
				REG_NPART:   cfg_q.particles_in_use    <= pwdata[6:0];
				REG_NDIM:    cfg_q.dims_in_use         <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'd0) begin
			unique case (idx)
				REG_INERTIA: prdata = {16'd0, cfg_q.inertia_weight};
				REG_GPULL:   prdata = {16'd0, cfg_q.global_pull_weight};
				REG_LPULL:   prdata = {16'd0, cfg_q.local_pull_weight};
				REG_VSCALE:  prdata = {16'd0, cfg_q.init_velocity_scale};
				REG_WRAP:    prdata = {31'd0, cfg_q.radian_wrap_enable};
				REG_NPART:   prdata = {25'd0, cfg_q.particles_in_use};
				REG_NDIM:    prdata = {27'd0, cfg_q.dims_in_use};
				default:     prdata = '0;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> sv/psu_core.sv
// Sequencer of the swarm engine: per-particle memories, clearing pass,
// read-modify-write of one dimension per item. Depends on psu_pkg.
`default_nettype none
module psu_core import psu_pkg::*; #(
	parameter int MAX_PARTICLES = 64,
	parameter int MAX_DIMS      = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire psu_cfg_t cfg,
	input  wire logic     start,
	input  wire psu_in_t  item,
	output logic          busy,
	output logic          done,
	output psu_out_t      result
);
	localparam int PW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int AW = PW + DW;
	localparam int DEPTH = 1 << AW;

	// report particle number folded into the particle range
	function automatic logic [64*PW-1:0] pid_table();
		logic [64*PW-1:0] t;
		for (int i = 0; i < 64; i++) t[i*PW +: PW] = PW'(i % MAX_PARTICLES);
		return t;
	endfunction
	localparam logic [64*PW-1:0] PID_MAP = pid_table();

	// memory word: position, velocity, own best position
	logic [95:0] pmem [DEPTH];
	logic signed [32:0] fmem [MAX_PARTICLES];
	logic signed [31:0] gbest [MAX_DIMS];
	logic signed [31:0] lo_mem [MAX_DIMS];
	logic signed [31:0] hi_mem [MAX_DIMS];

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_READ, S_MUL1, S_MUL2, S_SUM, S_FIX, S_WRITE
	} state_t;
	state_t state_q;

	logic [AW:0]  clr_q;
	psu_in_t      it_q;
	logic [PW-1:0] part_q, next_q;
	logic [6:0]   rcnt_q;
	logic [1:0]   pend_q;
	logic signed [32:0] gfit_q;
	logic         inuse_q, init_q;
	logic [95:0]  rd_q;
	logic signed [32:0] frd_q;
	logic signed [31:0] lo_q, hi_q, gb_q;
	logic signed [63:0] pa_q, pb_q, pc_q;
	logic signed [31:0] x_q, v_q;
	logic [15:0]  cg_q, cl_q;
	psu_out_t     res_q;
	psu_out_t     res_d;
	logic         done_q;

	localparam logic signed [32:0] FIT_NONE = -33'sd2147483649;

	logic [PW:0] npart_eff;
	logic [DW:0] ndim_eff;
	always_comb begin
		if (cfg.particles_in_use == 7'd0) npart_eff = (PW+1)'(1);
		else if (32'(cfg.particles_in_use) > MAX_PARTICLES) npart_eff = (PW+1)'(MAX_PARTICLES);
		else npart_eff = (PW+1)'(cfg.particles_in_use);
		if (cfg.dims_in_use == 5'd0) ndim_eff = (DW+1)'(1);
		else if (32'(cfg.dims_in_use) > MAX_DIMS) ndim_eff = (DW+1)'(MAX_DIMS);
		else ndim_eff = (DW+1)'(cfg.dims_in_use);
	end

	logic [DW-1:0] d_q;
	assign d_q = DW'(it_q.dim_index);
	logic [AW-1:0] addr;
	assign addr = {part_q, d_q};

	// pipeline arithmetic helpers
	logic signed [63:0] fsum;
	logic signed [31:0] vnew, pnew, vfix, pfix;
	logic signed [63:0] np;
	logic wrap;
	always_comb begin
		fsum = (pa_q >>> 12) + (pb_q >>> 12) + (pc_q >>> 12);
		vnew = sat32(fsum);
		np = 64'(x_q) + 64'(v_q);
		wrap = cfg.radian_wrap_enable && hi_q == TWO_PI_Q16 && lo_q == -TWO_PI_Q16;
		vfix = v_q;
		pfix = np[31:0];
		if (wrap) begin
			if (np > 64'(hi_q)) np = np - 64'(TWO_PI_Q16);
			if (np > 64'(hi_q)) np = np - 64'(TWO_PI_Q16);
			if (np < 64'(lo_q)) np = np + 64'(TWO_PI_Q16);
			if (np < 64'(lo_q)) np = np + 64'(TWO_PI_Q16);
			if (np > 64'(hi_q)) np = 64'(hi_q);
			if (np < 64'(lo_q)) np = 64'(lo_q);
			pfix = np[31:0];
		end else if (np > 64'(hi_q)) begin
			vfix = sat32(64'(hi_q) - 64'(x_q));
			pfix = hi_q;
		end else if (np < 64'(lo_q)) begin
			vfix = sat32(64'(lo_q) - 64'(x_q));
			pfix = lo_q;
		end else pfix = sat32(np);
		pnew = pfix;
	end

	logic signed [63:0] span;
	assign span = 64'(hi_q) - 64'(lo_q);

	logic l_new, g_new;
	assign l_new = 33'(signed'(it_q.fitness)) > frd_q;
	assign g_new = 33'(signed'(it_q.fitness)) > gfit_q;

	always_comb begin
		res_d = '0;
		res_d.kind = it_q.func;
		res_d.particle_out = 6'(part_q);
		res_d.dim_out = it_q.dim_index;
		res_d.last_out = it_q.last;
		if (it_q.func == FUNC_MOVE && inuse_q) begin
			if (init_q) begin
				res_d.position = x_q;
				res_d.velocity = sat32(pc_q >>> 12);
			end else begin
				res_d.position = pnew;
				res_d.velocity = vfix;
			end
		end
		if (it_q.func == FUNC_REPORT && inuse_q) begin
			if (d_q == '0) begin
				res_d.local_improved = l_new;
				res_d.global_improved = g_new;
			end else begin
				res_d.local_improved = pend_q[0];
				res_d.global_improved = pend_q[1];
			end
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign result = res_q;

	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) begin
			pmem[clr_q[AW-1:0]] <= '0;
			if (clr_q < (AW+1)'(MAX_PARTICLES))
				fmem[clr_q[PW-1:0]] <= FIT_NONE;
			if (clr_q < (AW+1)'(MAX_DIMS))
				gbest[clr_q[DW-1:0]] <= '0;
		end else if (state_q == S_READ) begin
			rd_q  <= pmem[addr];
			frd_q <= fmem[part_q];
			gb_q  <= gbest[d_q];
			lo_q  <= lo_mem[d_q];
			hi_q  <= hi_mem[d_q];
		end else if (state_q == S_WRITE && inuse_q) begin
			unique case (it_q.func)
				FUNC_MOVE: pmem[addr] <= {res_q.position, res_q.velocity, rd_q[31:0]};
				FUNC_REPORT: begin
					if (res_q.local_improved)
						pmem[addr] <= {rd_q[95:32], it_q.value};
					if (res_q.global_improved) gbest[d_q] <= it_q.value;
					if (d_q == '0 && l_new) fmem[part_q] <= 33'(signed'(it_q.fitness));
				end
				FUNC_LOAD: begin
					lo_mem[d_q] <= it_q.value;
					hi_mem[d_q] <= it_q.upper;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			next_q <= '0;
			rcnt_q <= '0;
			pend_q <= '0;
			gfit_q <= FIT_NONE;
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == S_WRITE);
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (start && item.func != FUNC_UNUSED) begin
					it_q <= item;
					part_q <= (item.func == FUNC_MOVE) ? next_q :
						(item.func == FUNC_REPORT) ? PID_MAP[32'(item.particle_id)*PW +: PW] : '0;
					inuse_q <= (DW+1)'(item.dim_index) < ndim_eff
						&& 32'(item.dim_index) < MAX_DIMS;
					init_q <= rcnt_q < 7'(npart_eff);
					state_q <= S_READ;
				end
				S_READ: state_q <= S_MUL1;
				S_MUL1: begin
					x_q <= rd_q[95:64];
					cg_q <= 16'((32'(cfg.global_pull_weight) * 32'(it_q.r_global)) >> 16);
					cl_q <= 16'((32'(cfg.local_pull_weight) * 32'(it_q.r_local)) >> 16);
					if (init_q) begin
						pa_q <= (span * signed'(64'(it_q.rand_pos))) >>> 16;
						pb_q <= (span * signed'(64'(it_q.rand_other))) >>> 16;
					end
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					if (init_q) begin
						pa_q <= 64'(sat32(64'(lo_q) + pa_q));
						pb_q <= 64'(lo_q) + pb_q;
					end else begin
						pa_q <= signed'(64'(cfg.inertia_weight)) * 64'(signed'(rd_q[63:32]));
						pb_q <= signed'(64'(cg_q)) * (64'(gb_q) - 64'(x_q));
						pc_q <= signed'(64'(cl_q)) * (64'(signed'(rd_q[31:0])) - 64'(x_q));
					end
					state_q <= S_SUM;
				end
				S_SUM: begin
					if (init_q) begin
						x_q <= pa_q[31:0];
						pc_q <= signed'(64'(cfg.init_velocity_scale)) * (pa_q - pb_q);
					end else v_q <= vnew;
					state_q <= S_FIX;
				end
				S_FIX: begin
					res_q <= res_d;
					if (it_q.func == FUNC_REPORT && inuse_q && d_q == '0) begin
						pend_q <= {g_new, l_new};
						if (g_new) gfit_q <= 33'(signed'(it_q.fitness));
						if (l_new && frd_q == FIT_NONE && rcnt_q != 7'd127)
							rcnt_q <= rcnt_q + 1'b1;
					end
					if (it_q.func == FUNC_MOVE && it_q.last)
						next_q <= ((PW+1)'(next_q) + 1'b1 >= npart_eff) ? '0 : next_q + 1'b1;
					state_q <= S_WRITE;
				end
				S_WRITE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> sv/particle_swarm_update.sv
// Top level of the particle swarm update engine.
// Depends on psu_pkg, psu_regs, psu_core.
//
// Usage: drive item and raise start while busy is low; the item transfers
// at that edge. Func move advances one dimension of the round-robin
// particle, report records a fitness element, load sets a dimension's bounds.
// One result appears on result with done high for exactly one cycle once
// the item has passed the read, two multiply stages, the sum, the clamp
// and the write-back of the state memory; the block then takes the next
// item and holds only one at a time. Func 3 gives no result.
// The receiver cannot stall: a result is taken in the cycle it is shown.
// After reset a clearing pass over every state memory entry (1024 entries
// with the default sizes) zeroes the state memory; busy stays high
// until it ends. Configuration writes over the APB port are taken at any
// time but are meant while the block idles.
`default_nettype none
module particle_swarm_update import psu_pkg::*; #(
	parameter int MAX_PARTICLES = 64,
	parameter int MAX_DIMS      = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        start,
	input  wire psu_in_t     item,
	output logic             busy,
	output logic             done,
	output psu_out_t         result
);
	psu_cfg_t cfg;
	assign pready = 1'b1;

	psu_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
	);

	psu_core #(.MAX_PARTICLES(MAX_PARTICLES), .MAX_DIMS(MAX_DIMS)) u_core (
		.clk, .arst_n, .cfg, .start, .item, .busy, .done, .result
	);
endmodule
`default_nettype wire

>>> verif/particle_swarm_update_test.sv
// Self-checking testbench for particle_swarm_update: command-style item transfers,
// APB register writes between phases, results checked against an in-bench predictor.
// Depends on psu_pkg and the particle_swarm_update RTL.
`timescale 1ns / 1ps
module particle_swarm_update_test;
	import psu_pkg::*;

	localparam int NPART = 64;
	localparam int NDIM = 16;
	localparam longint FIT_EMPTY = -64'sd2147483649;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 1'b0;
	psu_in_t item = '0;
	logic busy;
	logic done;
	psu_out_t result;

	particle_swarm_update dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .item(item), .busy(busy), .done(done), .result(result)
	);

	// Swarm state mirror
	psu_cfg_t cfg;
	logic signed [31:0] pos_mem [NPART*NDIM];
	logic signed [31:0] vel_mem [NPART*NDIM];
	logic signed [31:0] own_pos_mem [NPART*NDIM];
	longint own_fit [NPART];
	logic signed [31:0] swarm_pos [NDIM];
	longint swarm_fit;
	logic signed [31:0] lo_bound [NDIM];
	logic signed [31:0] hi_bound [NDIM];
	int cur_particle;
	int reported;
	logic [1:0] latched_flags;

	psu_in_t pending_items[$];
	psu_out_t expected_results[$];
	bit failed = 0;
	bit quiet = 0;
	int gap_left = 0;
	int stall_count = 0;
	longint fit_ramp = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic longint clip32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic int limit_of(int v, int top);
		if (v == 0) return 1;
		return (v > top) ? top : v;
	endfunction

	function automatic void mirror_reset();
		cfg.inertia_weight = 16'd3072;
		cfg.global_pull_weight = 16'd6144;
		cfg.local_pull_weight = 16'd6144;
		cfg.init_velocity_scale = 16'd1024;
		cfg.radian_wrap_enable = 1'b0;
		cfg.particles_in_use = 7'd64;
		cfg.dims_in_use = 5'd16;
		for (int i = 0; i < NPART*NDIM; i++) begin
			pos_mem[i] = 0;
			vel_mem[i] = 0;
			own_pos_mem[i] = 0;
		end
		for (int i = 0; i < NPART; i++) own_fit[i] = FIT_EMPTY;
		for (int i = 0; i < NDIM; i++) begin
			swarm_pos[i] = 0;
			lo_bound[i] = 0;
			hi_bound[i] = 0;
		end
		swarm_fit = FIT_EMPTY;
		cur_particle = 0;
		reported = 0;
		latched_flags = 2'b00;
	endfunction

	// Advance one dimension of a particle, either randomized or by the velocity rule
	function automatic void move_coord(int k, int d, psu_in_t it, output longint p_o,
			output longint v_o);
		longint lo, hi, x, v, np, span, p, t, cg, cl, sum;
		lo = longint'(lo_bound[d]);
		hi = longint'(hi_bound[d]);
		x = longint'(pos_mem[k]);
		if (reported < limit_of(cfg.particles_in_use, NPART)) begin
			span = hi - lo;
			p = lo + ((span * longint'(it.rand_pos)) >>> 16);
			t = lo + ((span * longint'(it.rand_other)) >>> 16);
			p = clip32(p);
			v = clip32((longint'(cfg.init_velocity_scale) * (p - t)) >>> 12);
			pos_mem[k] = p[31:0];
			vel_mem[k] = v[31:0];
			p_o = p;
			v_o = v;
			return;
		end
		cg = (longint'(cfg.global_pull_weight) * longint'(it.r_global)) >>> 16;
		cl = (longint'(cfg.local_pull_weight) * longint'(it.r_local)) >>> 16;
		sum = ((longint'(cfg.inertia_weight) * longint'(vel_mem[k])) >>> 12)
			+ ((cg * (longint'(swarm_pos[d]) - x)) >>> 12)
			+ ((cl * (longint'(own_pos_mem[k]) - x)) >>> 12);
		v = clip32(sum);
		np = x + v;
		if (cfg.radian_wrap_enable && hi == longint'(TWO_PI_Q16)
				&& lo == -longint'(TWO_PI_Q16)) begin
			for (int i = 0; i < 2 && np > hi; i++) np -= longint'(TWO_PI_Q16);
			for (int i = 0; i < 2 && np < lo; i++) np += longint'(TWO_PI_Q16);
			if (np > hi) np = hi;
			if (np < lo) np = lo;
		end else if (np > hi) begin
			v = clip32(hi - x);
			np = hi;
		end else if (np < lo) begin
			v = clip32(lo - x);
			np = lo;
		end
		np = clip32(np);
		pos_mem[k] = np[31:0];
		vel_mem[k] = v[31:0];
		p_o = np;
		v_o = v;
	endfunction

	function automatic void swarm_step(psu_in_t it);
		psu_out_t r;
		int d, part, n;
		bit in_use, l, g;
		longint p, v, fit;
		if (it.func == FUNC_UNUSED) return;
		d = it.dim_index;
		in_use = d < limit_of(cfg.dims_in_use, NDIM);
		part = 0;
		p = 0;
		v = 0;
		r = '0;
		if (it.func == FUNC_MOVE) begin
			part = cur_particle;
			if (in_use) move_coord(part*NDIM + d, d, it, p, v);
			if (it.last) begin
				n = cur_particle + 1;
				cur_particle = (n >= limit_of(cfg.particles_in_use, NPART)) ? 0 : n;
			end
		end else if (it.func == FUNC_REPORT) begin
			fit = longint'(it.fitness);
			part = it.particle_id;
			if (in_use) begin
				if (d == 0) begin
					l = fit > own_fit[part];
					g = fit > swarm_fit;
					if (l) begin
						if (own_fit[part] == FIT_EMPTY && reported < 127) reported++;
						own_fit[part] = fit;
					end
					if (g) swarm_fit = fit;
					latched_flags = {g, l};
				end
				r.local_improved = latched_flags[0];
				r.global_improved = latched_flags[1];
				if (latched_flags[0]) own_pos_mem[part*NDIM + d] = it.value;
				if (latched_flags[1]) swarm_pos[d] = it.value;
			end
		end else if (in_use) begin
			lo_bound[d] = it.value;
			hi_bound[d] = it.upper;
		end
		r.kind = it.func;
		r.particle_out = part[5:0];
		r.dim_out = d[3:0];
		r.position = p[31:0];
		r.velocity = v[31:0];
		r.last_out = it.last;
		expected_results = {expected_results, r};
	endfunction

	function automatic psu_in_t noise_item();
		psu_in_t it;
		it.func = 2'($urandom_range(0, 3));
		it.particle_id = 6'($urandom_range(0, 63));
		it.dim_index = 4'($urandom_range(0, 15));
		it.value = $urandom;
		it.upper = $urandom;
		it.fitness = $urandom;
		it.r_global = 16'($urandom_range(0, 65535));
		it.r_local = 16'($urandom_range(0, 65535));
		it.rand_pos = 16'($urandom_range(0, 65535));
		it.rand_other = 16'($urandom_range(0, 65535));
		it.last = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic psu_in_t load_item(int d, logic signed [31:0] lo,
			logic signed [31:0] hi);
		psu_in_t it;
		it = noise_item();
		it.func = FUNC_LOAD;
		it.dim_index = d[3:0];
		it.value = lo;
		it.upper = hi;
		return it;
	endfunction

	// Driver: present queued items, hold while busy, insert idle bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				swarm_step(item);
				void'(pending_items.pop_front());
			end
			if (start && busy) begin
				// hold the presented item
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (!quiet && pending_items.size() > 0 && $urandom_range(0, 19) == 0) begin
				gap_left = $urandom_range(0, 13);
				start <= 1'b0;
			end else if (pending_items.size() > 0) begin
				start <= 1'b1;
				item <= pending_items[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s expected %0d actual %0d", name, want, got);
			failed = 1;
		end
	endfunction

	// Monitor: every strobed result transfers at this edge
	always @(posedge clk) begin : monitor
		psu_out_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result with no expectation waiting");
				failed = 1;
			end else begin
				want = expected_results.pop_front();
				check_field("kind", want.kind, result.kind);
				check_field("particle_out", want.particle_out, result.particle_out);
				check_field("dim_out", want.dim_out, result.dim_out);
				check_field("position", longint'(want.position), longint'(result.position));
				check_field("velocity", longint'(want.velocity), longint'(result.velocity));
				check_field("local_improved", want.local_improved, result.local_improved);
				check_field("global_improved", want.global_improved, result.global_improved);
				check_field("last_out", want.last_out, result.last_out);
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) stall_count <= 0;
		else stall_count <= stall_count + 1;
		if (stall_count >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_INERTIA: cfg.inertia_weight = val[15:0];
			REG_GPULL:   cfg.global_pull_weight = val[15:0];
			REG_LPULL:   cfg.local_pull_weight = val[15:0];
			REG_VSCALE:  cfg.init_velocity_scale = val[15:0];
			REG_WRAP:    cfg.radian_wrap_enable = val[0];
			REG_NPART:   cfg.particles_in_use = val[6:0];
			REG_NDIM:    cfg.dims_in_use = val[4:0];
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (pending_items.size() != 0 || start || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_phase(int ph);
		if (ph == 1) begin
			reg_write(REG_INERTIA, 32'd0);
			reg_write(REG_GPULL, 32'd0);
			reg_write(REG_LPULL, 32'd0);
			reg_write(REG_VSCALE, 32'd0);
			reg_write(REG_WRAP, 32'd0);
			reg_write(REG_NPART, 32'd0);
			reg_write(REG_NDIM, 32'd0);
		end else if (ph == 2) begin
			reg_write(REG_INERTIA, 32'd65535);
			reg_write(REG_GPULL, 32'd65535);
			reg_write(REG_LPULL, 32'd65535);
			reg_write(REG_VSCALE, 32'd65535);
			reg_write(REG_WRAP, 32'd1);
			reg_write(REG_NPART, 32'd127);
			reg_write(REG_NDIM, 32'd31);
		end else begin
			reg_write(REG_INERTIA, $urandom_range(0, 8192));
			reg_write(REG_GPULL, $urandom_range(0, 16384));
			reg_write(REG_LPULL, $urandom_range(0, 16384));
			reg_write(REG_VSCALE, $urandom_range(0, 4096));
			reg_write(REG_WRAP, $urandom_range(0, 1));
			reg_write(REG_NPART, $urandom_range(1, 6));
			reg_write(REG_NDIM, $urandom_range(1, 16));
		end
	endtask

	task automatic fill_random(int count);
		psu_in_t it;
		int nd, sel, pid, lo;
		nd = limit_of(cfg.dims_in_use, NDIM);
		while (count > 0) begin
			sel = $urandom_range(0, 99);
			if (sel < 50) begin
				for (int d = 0; d < nd; d++) begin
					it = noise_item();
					it.func = FUNC_MOVE;
					it.dim_index = d[3:0];
					it.last = (d == nd - 1);
					pending_items = {pending_items, it};
					count--;
				end
			end else if (sel < 85) begin
				pid = $urandom_range(0, limit_of(cfg.particles_in_use, NPART) - 1);
				fit_ramp += $urandom_range(0, 3) - 1;
				for (int d = 0; d < nd; d++) begin
					it = noise_item();
					it.func = FUNC_REPORT;
					it.particle_id = pid[5:0];
					it.dim_index = d[3:0];
					it.last = (d == nd - 1);
					if ($urandom_range(0, 1)) it.fitness = fit_ramp[31:0];
					pending_items = {pending_items, it};
					count--;
				end
			end else if (sel < 90) begin
				if (cfg.radian_wrap_enable && $urandom_range(0, 1))
					it = load_item($urandom_range(0, 15), -TWO_PI_Q16, TWO_PI_Q16);
				else begin
					lo = $urandom_range(0, 2000000) - 1000000;
					it = load_item($urandom_range(0, 15), lo, lo + $urandom_range(0, 3000000));
				end
				pending_items = {pending_items, it};
				count--;
			end else begin
				pending_items = {pending_items, noise_item()};
				count--;
			end
		end
	endtask

	initial begin : stimulus
		psu_in_t it;
		mirror_reset();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Bounds for every dimension first, extremes and the two-pi pair among them
		pending_items = {pending_items, load_item(0, 32'sh80000000, 32'sh7fffffff)};
		pending_items = {pending_items, load_item(1, -TWO_PI_Q16, TWO_PI_Q16)};
		pending_items = {pending_items, load_item(2, 32'sd0, 32'sd0)};
		pending_items = {pending_items, load_item(3, -TWO_PI_Q16, TWO_PI_Q16)};
		for (int d = 4; d < NDIM; d++)
			pending_items = {pending_items, load_item(d, -32'sd65536 * d, 32'sd65536 * d)};
		it = noise_item();
		it.func = FUNC_MOVE; it.dim_index = 4'd0; it.last = 1'b0;
		it.rand_pos = 16'hffff; it.rand_other = 16'h0000;
		pending_items = {pending_items, it};
		it = noise_item();
		it.func = FUNC_MOVE; it.dim_index = 4'd15; it.last = 1'b1;
		it.rand_pos = 16'h0000; it.rand_other = 16'hffff;
		pending_items = {pending_items, it};
		it = noise_item();
		it.func = FUNC_REPORT; it.particle_id = 6'd0; it.dim_index = 4'd0;
		it.fitness = 32'sh80000000; it.value = 32'sh7fffffff;
		pending_items = {pending_items, it};
		it = noise_item();
		it.func = FUNC_REPORT; it.particle_id = 6'd63; it.dim_index = 4'd0;
		it.fitness = 32'sh7fffffff; it.value = 32'sh80000000;
		pending_items = {pending_items, it};
		it = noise_item();
		it.func = FUNC_REPORT; it.particle_id = 6'd63; it.dim_index = 4'd15; it.last = 1'b1;
		pending_items = {pending_items, it};
		it = noise_item();
		it.func = FUNC_UNUSED;
		pending_items = {pending_items, it};
		wait_idle();

		for (int ph = 0; ph < 8; ph++) begin
			if (ph > 0) set_phase(ph);
			if (ph == 7) quiet = 1;
			fill_random(175);
			wait_idle();
		end

		if (!failed && expected_results.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
